FILE: rtl/gdd_pkg.sv
`timescale 1ns / 1ps
// gdd_pkg: widths, status codes and calendar tables for the date difference core
// no dependencies

package gdd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DIFF_W  = 23;
   localparam int STAT_W  = 2;

   localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_FIRST  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_SECOND = 2'd2;

   localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [DIFF_W-1:0]  count_type;

   // month length in a common year, zero for month codes that mean nothing
   function automatic day_type month_len(input month_type m);
      day_type len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days of a common year before the first of the month
   function automatic logic [8:0] days_before(input month_type m);
      logic [8:0] n;
      case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/gregorian_date_difference_core.sv
`timescale 1ns / 1ps
// gregorian_date_difference_core: signed day count between two gregorian dates
// depends on gdd_pkg
//
// channel  dir  ports                                           role
// req      in   req_valid/ready, first_*, second_* day/month/year  two dates
// rsp      out  rsp_valid/ready, rsp_status, rsp_day_difference     one result
//
// a single year counter with running day total walks from year 1 up to the
// later valid year, one year a cycle, latching the totals of both years
// req_ready is high only when no item is in work and no result is held
// synchronous active-high reset clears the sequencer and rsp_valid

module gregorian_date_difference_core
   import gdd_pkg::*;
#(
   parameter int MAX_YEAR = 9999
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [DAY_W-1:0]         req_first_day,
   input  logic [MONTH_W-1:0]       req_first_month,
   input  logic [YEAR_W-1:0]        req_first_year,
   input  logic [DAY_W-1:0]         req_second_day,
   input  logic [MONTH_W-1:0]       req_second_month,
   input  logic [YEAR_W-1:0]        req_second_year,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DIFF_W-1:0] rsp_day_difference
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_FIRST  = 3'd2;
   localparam logic [2:0] S_SECOND = 3'd3;
   localparam logic [2:0] S_DIFF   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]  state_ff, state_in;

   day_type     d1_ff, d2_ff;
   month_type   m1_ff, m2_ff;
   year_type    y1_ff, y2_ff, end_ff, end_in;
   logic        yok1_ff, yok2_ff, yok1_in, yok2_in;

   year_type    year_ff, year_in;
   logic [1:0]  mod4_ff, mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;
   count_type   acc_ff, acc_in;
   count_type   base1_ff, base1_in, base2_ff, base2_in;
   logic        leap1_ff, leap1_in, leap2_ff, leap2_in;

   logic [STAT_W-1:0] status_ff, status_in;
   count_type         diff_ff, diff_in;

   logic        leap_now;
   logic        ok1, ok2;
   day_type     len1, len2;

   assign leap_now = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);

   always_comb begin
      len1 = leap1_ff && (m1_ff == MON_FEB) ? 5'd29 : month_len(m1_ff);
      len2 = leap2_ff && (m2_ff == MON_FEB) ? 5'd29 : month_len(m2_ff);
      ok1  = yok1_ff && (m1_ff != 4'd0) && (m1_ff <= MON_DEC) && (d1_ff != 5'd0) &&
             (d1_ff <= len1);
      ok2  = yok2_ff && (m2_ff != 4'd0) && (m2_ff <= MON_DEC) && (d2_ff != 5'd0) &&
             (d2_ff <= len2);
   end

   always_comb begin
      state_in  = state_ff;
      end_in    = end_ff;
      yok1_in   = yok1_ff;
      yok2_in   = yok2_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      acc_in    = acc_ff;
      base1_in  = base1_ff;
      base2_in  = base2_ff;
      leap1_in  = leap1_ff;
      leap2_in  = leap2_ff;
      status_in = status_ff;
      diff_in   = diff_ff;
      case (state_ff)
         S_IDLE: begin
            yok1_in   = (req_first_year != '0) && (32'(req_first_year) <= MAX_YEAR);
            yok2_in   = (req_second_year != '0) && (32'(req_second_year) <= MAX_YEAR);
            // walk only as far as the later valid year
            if (yok1_in && yok2_in)
               end_in = (req_first_year > req_second_year) ? req_first_year
                                                           : req_second_year;
            else if (yok1_in)
               end_in = req_first_year;
            else if (yok2_in)
               end_in = req_second_year;
            else
               end_in = YEAR_W'(1);
            year_in   = YEAR_W'(1);
            mod4_in   = 2'd1;
            mod100_in = 7'd1;
            mod400_in = 9'd1;
            acc_in    = '0;
            if (req_valid)
               state_in = S_WALK;
         end
         S_WALK: begin
            if (year_ff == y1_ff) begin
               base1_in = acc_ff;
               leap1_in = leap_now;
            end
            if (year_ff == y2_ff) begin
               base2_in = acc_ff;
               leap2_in = leap_now;
            end
            if (year_ff == end_ff) begin
               state_in = S_FIRST;
            end else begin
               year_in   = year_ff + YEAR_W'(1);
               acc_in    = acc_ff + DIFF_W'(365) + DIFF_W'(leap_now);
               mod4_in   = mod4_ff + 2'd1;
               mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
            end
         end
         S_FIRST: begin
            if (!ok1) begin
               status_in = STAT_BAD_FIRST;
               diff_in   = '0;
               state_in  = S_DONE;
            end else begin
               base1_in = base1_ff + DIFF_W'(days_before(m1_ff)) +
                          DIFF_W'(leap1_ff && (m1_ff > MON_FEB)) + DIFF_W'(d1_ff);
               state_in = S_SECOND;
            end
         end
         S_SECOND: begin
            if (!ok2) begin
               status_in = STAT_BAD_SECOND;
               diff_in   = '0;
               state_in  = S_DONE;
            end else begin
               base2_in = base2_ff + DIFF_W'(days_before(m2_ff)) +
                          DIFF_W'(leap2_ff && (m2_ff > MON_FEB)) + DIFF_W'(d2_ff);
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            // modular subtract gives the two's complement count
            diff_in   = base2_ff - base1_ff;
            status_in = STAT_OK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (rsp_ready)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         d1_ff <= req_first_day;
         m1_ff <= req_first_month;
         y1_ff <= req_first_year;
         d2_ff <= req_second_day;
         m2_ff <= req_second_month;
         y2_ff <= req_second_year;
      end
      end_ff    <= end_in;
      yok1_ff   <= yok1_in;
      yok2_ff   <= yok2_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      acc_ff    <= acc_in;
      base1_ff  <= base1_in;
      base2_ff  <= base2_in;
      leap1_ff  <= leap1_in;
      leap2_ff  <= leap2_in;
      status_ff <= status_in;
      diff_ff   <= diff_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = (state_ff == S_DONE);
   assign rsp_status         = status_ff;
   assign rsp_day_difference = diff_ff;

endmodule
